### rtl/laser_scan_cluster_segmenter_core_defines.svh
// assertion macros shared by the segmenter modules
// no dependencies
`ifndef LASER_SCAN_CLUSTER_SEGMENTER_CORE_DEFINES_SVH
`define LASER_SCAN_CLUSTER_SEGMENTER_CORE_DEFINES_SVH

// same-cycle implication
`define LSCS_ASSERT_IMP(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("lscs assertion failed");

// next-cycle implication
`define LSCS_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("lscs assertion failed");

`endif

### rtl/lscs_pkg.sv
// types, constants and command/status structs of the scan segmenter
// no dependencies
package lscs_pkg;

	localparam int unsigned MAX_POINTS = 2048;
	localparam int POS_W  = 24;
	localparam int CELL_W = 17;
	localparam int CNT_W  = 12;
	localparam int SUM_W  = 36;
	localparam int SPAN_W = 18;
	localparam int LANES  = 3;
	localparam int DIV_CNT_W = $clog2(SUM_W);

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

	localparam logic [15:0] NEAR_GAP_RST  = 16'd205;
	localparam logic [22:0] FAR_RANGE_RST = 23'd23552;
	localparam logic [15:0] FAR_SLOPE_RST = 16'd572;

	localparam logic [SPAN_W-1:0] SPAN_MIN = 18'd2;
	localparam logic [SPAN_W-1:0] SPAN_LIM = 18'd20;
	localparam logic [9:0]        AREA_LIM = 10'd400;

	typedef enum logic [2:0] {
		REG_SENSOR_X,
		REG_SENSOR_Y,
		REG_SENSOR_Z,
		REG_NEAR_GAP,
		REG_FAR_RANGE,
		REG_FAR_SLOPE
	} reg_idx_t;

	typedef struct packed {
		logic signed [POS_W-1:0] sensor_x;
		logic signed [POS_W-1:0] sensor_y;
		logic signed [POS_W-1:0] sensor_z;
		logic [15:0]             near_gap;
		logic [22:0]             far_range;
		logic [15:0]             far_slope;
	} cfg_t;

	// multiplier schedule of the gap test
	typedef enum logic [3:0] {
		MS_DX,
		MS_DY,
		MS_NG,
		MS_RX,
		MS_RY,
		MS_FR,
		MS_SL,
		MS_TLO,
		MS_THI
	} mstep_t;

	typedef struct packed {
		logic   load_pt;
		logic   mul;
		logic   acc;
		mstep_t step;
		logic   start;
		logic   join_pt;
		logic   div_init;
		logic   div_step;
		logic   out_load;
		logic   out_last;
		logic   clear;
	} dp_cmd_t;

	typedef struct packed {
		logic open;
		logic scan_end;
		logic join_ok;
		logic out_free;
	} dp_stat_t;

endpackage

### rtl/lscs_regs.sv
// configuration register file on the apb-style port
// depends on lscs_pkg
module lscs_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output lscs_pkg::cfg_t   cfg
);

	lscs_pkg::cfg_t cfg_q;
	lscs_pkg::reg_idx_t idx;

	assign idx    = lscs_pkg::reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_x  <= '0;
			cfg_q.sensor_y  <= '0;
			cfg_q.sensor_z  <= '0;
			cfg_q.near_gap  <= lscs_pkg::NEAR_GAP_RST;
			cfg_q.far_range <= lscs_pkg::FAR_RANGE_RST;
			cfg_q.far_slope <= lscs_pkg::FAR_SLOPE_RST;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				lscs_pkg::REG_SENSOR_X:  cfg_q.sensor_x  <= pwdata[23:0];
				lscs_pkg::REG_SENSOR_Y:  cfg_q.sensor_y  <= pwdata[23:0];
				lscs_pkg::REG_SENSOR_Z:  cfg_q.sensor_z  <= pwdata[23:0];
				lscs_pkg::REG_NEAR_GAP:  cfg_q.near_gap  <= pwdata[15:0];
				lscs_pkg::REG_FAR_RANGE: cfg_q.far_range <= pwdata[22:0];
				lscs_pkg::REG_FAR_SLOPE: cfg_q.far_slope <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			lscs_pkg::REG_SENSOR_X:  prdata = {8'd0, cfg_q.sensor_x};
			lscs_pkg::REG_SENSOR_Y:  prdata = {8'd0, cfg_q.sensor_y};
			lscs_pkg::REG_SENSOR_Z:  prdata = {8'd0, cfg_q.sensor_z};
			lscs_pkg::REG_NEAR_GAP:  prdata = {16'd0, cfg_q.near_gap};
			lscs_pkg::REG_FAR_RANGE: prdata = {9'd0, cfg_q.far_range};
			lscs_pkg::REG_FAR_SLOPE: prdata = {16'd0, cfg_q.far_slope};
			default:                 prdata = '0;
		endcase
	end

endmodule

### rtl/lscs_ctrl.sv
// controller: sequences gap test, cluster update, centroid divide and output
// depends on lscs_pkg and the assertion macro header
`include "laser_scan_cluster_segmenter_core_defines.svh"
module lscs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               point_valid,
	output logic               point_ready,
	input  lscs_pkg::dp_stat_t st,
	output lscs_pkg::dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_DECIDE,
		S_JOIN,
		S_START,
		S_DIV_INIT,
		S_DIV,
		S_OUT,
		S_CLEAR
	} state_t;

	state_t state_q;
	lscs_pkg::mstep_t step_q;
	logic [lscs_pkg::DIV_CNT_W-1:0] cnt_q;
	logic pend_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= lscs_pkg::MS_DX;
			cnt_q        <= '0;
			pend_start_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					step_q <= lscs_pkg::MS_DX;
					if (point_valid) begin
						state_q <= st.open ? S_MUL : S_START;
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					if (step_q == lscs_pkg::MS_THI) begin
						state_q <= S_DECIDE;
					end else begin
						step_q  <= lscs_pkg::mstep_t'(step_q + 4'd1);
						state_q <= S_MUL;
					end
				end
				S_DECIDE: begin
					if (st.join_ok) begin
						state_q <= S_JOIN;
					end else begin
						pend_start_q <= 1'b1;
						state_q      <= S_DIV_INIT;
					end
				end
				S_JOIN: state_q <= st.scan_end ? S_DIV_INIT : S_IDLE;
				S_START: begin
					pend_start_q <= 1'b0;
					state_q      <= st.scan_end ? S_DIV_INIT : S_IDLE;
				end
				S_DIV_INIT: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == lscs_pkg::DIV_LAST) begin
						state_q <= S_OUT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_OUT: begin
					if (st.out_free) begin
						state_q <= pend_start_q ? S_START : S_CLEAR;
					end
				end
				S_CLEAR: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign point_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load_pt  = (state_q == S_IDLE) && point_valid;
		cmd.mul      = (state_q == S_MUL);
		cmd.acc      = (state_q == S_ACC);
		cmd.step     = step_q;
		cmd.start    = (state_q == S_START);
		cmd.join_pt  = (state_q == S_JOIN);
		cmd.div_init = (state_q == S_DIV_INIT);
		cmd.div_step = (state_q == S_DIV);
		cmd.out_load = (state_q == S_OUT) && st.out_free;
		cmd.out_last = !pend_start_q;
		cmd.clear    = (state_q == S_CLEAR);
	end

	`LSCS_ASSERT_NEXT(a_split_pends, clk, arst_n, (state_q == S_DECIDE) && !st.join_ok, pend_start_q)
	`LSCS_ASSERT_IMP(a_join_no_pend, clk, arst_n, state_q == S_JOIN, !pend_start_q)

endmodule

### rtl/lscs_dpath.sv
// datapath: shared multiplier, gap test, cluster accumulators, centroid divider, output word
// depends on lscs_pkg and the assertion macro header
`include "laser_scan_cluster_segmenter_core_defines.svh"
module lscs_dpath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lscs_pkg::cfg_t            cfg,
	input  lscs_pkg::dp_cmd_t         cmd,
	output lscs_pkg::dp_stat_t        st,
	input  logic signed [23:0]        point_x,
	input  logic signed [23:0]        point_y,
	input  logic signed [23:0]        point_z,
	input  logic signed [16:0]        cell_col,
	input  logic signed [16:0]        cell_row,
	input  logic                      scan_end,
	output logic                      cluster_valid,
	input  logic                      cluster_ready,
	output logic [11:0]               cluster_label,
	output logic [11:0]               point_count,
	output logic [17:0]               col_span,
	output logic [17:0]               row_span,
	output logic signed [23:0]        center_x,
	output logic signed [23:0]        center_y,
	output logic signed [23:0]        center_z,
	output logic                      size_ok,
	output logic                      last_of_scan
);

	localparam int PW = lscs_pkg::POS_W;
	localparam int CW = lscs_pkg::CELL_W;
	localparam int NW = lscs_pkg::CNT_W;
	localparam int SW = lscs_pkg::SUM_W;
	localparam int L  = lscs_pkg::LANES;

	// point word and previous point
	logic signed [PW-1:0] pt_q [L];
	logic signed [CW-1:0] col_q, row_q;
	logic                 end_q;
	logic signed [PW-1:0] prev_x_q, prev_y_q;

	// gap test
	logic signed [PW:0] dx, dy, rx, ry;
	logic [PW:0]        mdx, mdy, mrx, mry;
	logic [31:0]        op_a;
	logic [25:0]        op_b;
	logic [57:0]        prod_q;
	logic [50:0]        d2_q, r2_q;
	logic [31:0]        ng2_q, sl2_q;
	logic [45:0]        fr2_q;
	logic [82:0]        th_q;
	logic               pose_nz, near_ok, far_sel, far_ok;

	// cluster state
	logic                 open_q;
	logic [NW-1:0]        lbl_q, mem_cnt_q;
	logic signed [CW-1:0] col_min_q, col_max_q, row_min_q, row_max_q;
	logic signed [SW-1:0] sum_q [L];

	// centroid divider lanes
	logic [SW-1:0] dq_q  [L];
	logic [NW-1:0] rem_q [L];
	logic          neg_q [L];
	logic [NW:0]   trial [L];
	logic          ge    [L];
	logic [PW-1:0] cen   [L];

	// output word
	logic                 out_valid_q;
	logic [NW-1:0]        lbl_out_q, cnt_out_q;
	logic [17:0]          cs_out_q, rs_out_q;
	logic signed [PW-1:0] cen_out_q [L];
	logic                 ok_out_q, last_out_q;
	logic [17:0]          cs, rs;
	logic                 ok_w;

	function automatic logic [PW:0] mag(input logic signed [PW:0] v);
		return v[PW] ? $unsigned(-v) : $unsigned(v);
	endfunction

	assign dx  = {pt_q[0][PW-1], pt_q[0]} - {prev_x_q[PW-1], prev_x_q};
	assign dy  = {pt_q[1][PW-1], pt_q[1]} - {prev_y_q[PW-1], prev_y_q};
	assign rx  = {pt_q[0][PW-1], pt_q[0]} - {cfg.sensor_x[PW-1], cfg.sensor_x};
	assign ry  = {pt_q[1][PW-1], pt_q[1]} - {cfg.sensor_y[PW-1], cfg.sensor_y};
	assign mdx = mag(dx);
	assign mdy = mag(dy);
	assign mrx = mag(rx);
	assign mry = mag(ry);

	always_comb begin
		case (cmd.step)
			lscs_pkg::MS_DX: begin
				op_a = 32'(mdx);
				op_b = 26'(mdx);
			end
			lscs_pkg::MS_DY: begin
				op_a = 32'(mdy);
				op_b = 26'(mdy);
			end
			lscs_pkg::MS_NG: begin
				op_a = 32'(cfg.near_gap);
				op_b = 26'(cfg.near_gap);
			end
			lscs_pkg::MS_RX: begin
				op_a = 32'(mrx);
				op_b = 26'(mrx);
			end
			lscs_pkg::MS_RY: begin
				op_a = 32'(mry);
				op_b = 26'(mry);
			end
			lscs_pkg::MS_FR: begin
				op_a = 32'(cfg.far_range);
				op_b = 26'(cfg.far_range);
			end
			lscs_pkg::MS_SL: begin
				op_a = 32'(cfg.far_slope);
				op_b = 26'(cfg.far_slope);
			end
			lscs_pkg::MS_TLO: begin
				op_a = sl2_q;
				op_b = r2_q[25:0];
			end
			lscs_pkg::MS_THI: begin
				op_a = sl2_q;
				op_b = {1'b0, r2_q[50:26]};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= op_a * op_b;
		end
		if (cmd.acc) begin
			case (cmd.step)
				lscs_pkg::MS_DX:  d2_q  <= 51'(prod_q);
				lscs_pkg::MS_DY:  d2_q  <= d2_q + 51'(prod_q);
				lscs_pkg::MS_NG:  ng2_q <= 32'(prod_q);
				lscs_pkg::MS_RX:  r2_q  <= 51'(prod_q);
				lscs_pkg::MS_RY:  r2_q  <= r2_q + 51'(prod_q);
				lscs_pkg::MS_FR:  fr2_q <= 46'(prod_q);
				lscs_pkg::MS_SL:  sl2_q <= 32'(prod_q);
				lscs_pkg::MS_TLO: th_q  <= 83'(prod_q);
				lscs_pkg::MS_THI: th_q  <= th_q + {prod_q[56:0], 26'd0};
				default: ;
			endcase
		end
	end

	assign pose_nz = (cfg.sensor_x != '0) || (cfg.sensor_y != '0) || (cfg.sensor_z != '0);
	assign near_ok = d2_q < {19'd0, ng2_q};
	assign far_sel = pose_nz && (r2_q >= {5'd0, fr2_q});
	assign far_ok  = {d2_q, 32'd0} < th_q;

	// point word and previous point
	always_ff @(posedge clk) begin
		if (cmd.load_pt) begin
			pt_q[0] <= point_x;
			pt_q[1] <= point_y;
			pt_q[2] <= point_z;
			col_q   <= cell_col;
			row_q   <= cell_row;
			end_q   <= scan_end;
		end
		if (cmd.start || cmd.join_pt) begin
			prev_x_q <= pt_q[0];
			prev_y_q <= pt_q[1];
		end
	end

	// cluster control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b0;
			lbl_q     <= '0;
			mem_cnt_q <= '0;
		end else if (cmd.start) begin
			open_q    <= 1'b1;
			mem_cnt_q <= NW'(1);
			if (lbl_q < lscs_pkg::CNT_MAX) begin
				lbl_q <= lbl_q + 1'b1;
			end
		end else if (cmd.join_pt) begin
			if (mem_cnt_q < lscs_pkg::CNT_MAX) begin
				mem_cnt_q <= mem_cnt_q + 1'b1;
			end
		end else if (cmd.clear) begin
			open_q <= 1'b0;
			lbl_q  <= '0;
		end
	end

	// cluster sums and cell bounds
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < L; i++) begin
				sum_q[i] <= SW'(pt_q[i]);
			end
			col_min_q <= col_q;
			col_max_q <= col_q;
			row_min_q <= row_q;
			row_max_q <= row_q;
		end else if (cmd.join_pt) begin
			if (mem_cnt_q < lscs_pkg::CNT_MAX) begin
				for (int i = 0; i < L; i++) begin
					sum_q[i] <= sum_q[i] + SW'(pt_q[i]);
				end
			end
			if (col_q < col_min_q) col_min_q <= col_q;
			if (col_q > col_max_q) col_max_q <= col_q;
			if (row_q < row_min_q) row_min_q <= row_q;
			if (row_q > row_max_q) row_max_q <= row_q;
		end
	end

	// restoring divide, one quotient bit per cycle in each lane
	always_comb begin
		for (int i = 0; i < L; i++) begin
			trial[i] = {rem_q[i], dq_q[i][SW-1]};
			ge[i]    = trial[i] >= {1'b0, mem_cnt_q};
			cen[i]   = neg_q[i] ? (PW'(0) - dq_q[i][PW-1:0]) : dq_q[i][PW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			for (int i = 0; i < L; i++) begin
				neg_q[i] <= sum_q[i][SW-1];
				rem_q[i] <= '0;
				dq_q[i]  <= (sum_q[i][SW-1] ? $unsigned(-sum_q[i]) : $unsigned(sum_q[i]))
					+ SW'(mem_cnt_q >> 1);
			end
		end else if (cmd.div_step) begin
			for (int i = 0; i < L; i++) begin
				rem_q[i] <= ge[i] ? NW'(trial[i] - {1'b0, mem_cnt_q}) : trial[i][NW-1:0];
				dq_q[i]  <= {dq_q[i][SW-2:0], ge[i]};
			end
		end
	end

	assign cs = {col_max_q[CW-1], col_max_q} - {col_min_q[CW-1], col_min_q} + 18'd1;
	assign rs = {row_max_q[CW-1], row_max_q} - {row_min_q[CW-1], row_min_q} + 18'd1;
	assign ok_w = (cs >= lscs_pkg::SPAN_MIN) && (cs < lscs_pkg::SPAN_LIM)
		&& (rs >= lscs_pkg::SPAN_MIN) && (rs < lscs_pkg::SPAN_LIM)
		&& ((cs[4:0] * rs[4:0]) < lscs_pkg::AREA_LIM);

	// output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (cluster_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			lbl_out_q  <= lbl_q;
			cnt_out_q  <= mem_cnt_q;
			cs_out_q   <= cs;
			rs_out_q   <= rs;
			ok_out_q   <= ok_w;
			last_out_q <= cmd.out_last;
			for (int i = 0; i < L; i++) begin
				cen_out_q[i] <= cen[i];
			end
		end
	end

	assign st.open     = open_q;
	assign st.scan_end = end_q;
	assign st.join_ok  = far_sel ? far_ok : near_ok;
	assign st.out_free = !out_valid_q || cluster_ready;

	assign cluster_valid = out_valid_q;
	assign cluster_label = lbl_out_q;
	assign point_count   = cnt_out_q;
	assign col_span      = cs_out_q;
	assign row_span      = rs_out_q;
	assign center_x      = cen_out_q[0];
	assign center_y      = cen_out_q[1];
	assign center_z      = cen_out_q[2];
	assign size_ok       = ok_out_q;
	assign last_of_scan  = last_out_q;

	`LSCS_ASSERT_IMP(a_cnt_range, clk, arst_n, open_q, (mem_cnt_q != '0) && (mem_cnt_q <= lscs_pkg::CNT_MAX))
	`LSCS_ASSERT_IMP(a_join_open, clk, arst_n, cmd.join_pt || cmd.div_init, open_q)
	`LSCS_ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.out_load, cluster_valid && (cluster_label == $past(lbl_q)))

endmodule

### rtl/laser_scan_cluster_segmenter_core.sv
// top level of the laser scan cluster segmenter
// depends on lscs_pkg, lscs_regs, lscs_ctrl and lscs_dpath
//
//  channel   direction  handshake                  word
//  point     in         point_valid/point_ready    point_x..z, cell_col, cell_row, scan_end
//  cluster   out        cluster_valid/cluster_ready label, count, spans, centre, flags
//  apb       in         psel/penable/pwrite/pready config registers at 4*index
//
// a joining point makes nine passes through the shared multiplier
// a point that closes a cluster runs the gap test, the centroid divide and then starts a new one
// scan_end adds a final divide of the open cluster; the first point of a scan starts a cluster directly
// reset clears control state and loads the configuration defaults; no clearing pass is needed
// a held output word stalls the block only when the next word is ready to load
module laser_scan_cluster_segmenter_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               point_valid,
	output logic               point_ready,
	input  logic signed [23:0] point_x,
	input  logic signed [23:0] point_y,
	input  logic signed [23:0] point_z,
	input  logic signed [16:0] cell_col,
	input  logic signed [16:0] cell_row,
	input  logic               scan_end,
	output logic               cluster_valid,
	input  logic               cluster_ready,
	output logic [11:0]        cluster_label,
	output logic [11:0]        point_count,
	output logic [17:0]        col_span,
	output logic [17:0]        row_span,
	output logic signed [23:0] center_x,
	output logic signed [23:0] center_y,
	output logic signed [23:0] center_z,
	output logic               size_ok,
	output logic               last_of_scan
);

	lscs_pkg::cfg_t     cfg;
	lscs_pkg::dp_cmd_t  cmd;
	lscs_pkg::dp_stat_t st;

	lscs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lscs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.point_ready (point_ready),
		.st          (st),
		.cmd         (cmd)
	);

	lscs_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.st            (st),
		.point_x       (point_x),
		.point_y       (point_y),
		.point_z       (point_z),
		.cell_col      (cell_col),
		.cell_row      (cell_row),
		.scan_end      (scan_end),
		.cluster_valid (cluster_valid),
		.cluster_ready (cluster_ready),
		.cluster_label (cluster_label),
		.point_count   (point_count),
		.col_span      (col_span),
		.row_span      (row_span),
		.center_x      (center_x),
		.center_y      (center_y),
		.center_z      (center_z),
		.size_ok       (size_ok),
		.last_of_scan  (last_of_scan)
	);

endmodule
